@@ src/wfq_pkg.sv @@
// Package: shared types and constants for the weighted fair queue scheduler.
`timescale 1ns / 1ps

package wfq_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int FIFO_DEPTH = 16;
    localparam int QW         = $clog2(NUM_QUEUES);
    localparam int PW         = $clog2(FIFO_DEPTH);
    localparam int CW         = $clog2(FIFO_DEPTH + 1);
    localparam int MW         = $clog2(NUM_QUEUES * FIFO_DEPTH);
    localparam int TAG_W      = 48;
    localparam int LEN_W      = 16;
    localparam int WGT_W      = 16;
    localparam int NUM_REGS   = 4;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
    localparam logic [WGT_W-1:0] WGT_RESET = 16'd256;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ENQ   = 1'b0,
        ACT_SERVE = 1'b1
    } t_action;

    // command handed from the front end to the back end
    typedef struct packed {
        t_action          action;
        logic [1:0]       queue_sel;
        logic [LEN_W-1:0] packet_len;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_READ  = 2'd1,
        BS_TAG   = 2'd2,
        BS_OUT   = 2'd3
    } t_bstate;

    // saturating tag = start + len * w
    function automatic logic [TAG_W-1:0] sat_add(input logic [TAG_W-1:0] a,
                                                 input logic [31:0] p);
        logic [TAG_W:0] s;
        s = {1'b0, a} + {{(TAG_W + 1 - 32){1'b0}}, p};
        return s[TAG_W] ? TAG_MAX : s[TAG_W-1:0];
    endfunction

endpackage

@@ src/wfq_front.sv @@
// Front end: takes input beats and buffers them in a short command queue.
`timescale 1ns / 1ps

module wfq_front import wfq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);

    localparam int AW = $clog2(CMDQ_DEPTH);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [AW-1:0]       r_wr, r_rd;
    logic [AW:0]         r_cnt;
    logic                w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(CMDQ_DEPTH)) else $error("command queue overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(CMDQ_DEPTH)) |-> !w_push) else $error("push when full");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 1'b1)) else $error("pop count");
`endif

endmodule

@@ src/wfq_back.sv @@
// Back end: queue state, tag arithmetic, selection and result register.
`timescale 1ns / 1ps

module wfq_back import wfq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [WGT_W-1:0]  i_cfg_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_status           o_status,
    output logic [1:0]        o_served_queue,
    output logic [LEN_W-1:0]  o_served_len,
    output logic [TAG_W-1:0]  o_virtual_time
);

    logic [LEN_W-1:0] r_fifo [NUM_QUEUES * FIFO_DEPTH];
    logic [PW-1:0]    r_head [NUM_QUEUES];
    logic [PW-1:0]    r_tail [NUM_QUEUES];
    logic [CW-1:0]    r_count [NUM_QUEUES];
    logic [TAG_W-1:0] r_finish [NUM_QUEUES];
    logic [WGT_W-1:0] r_wgt [NUM_REGS];
    logic [TAG_W-1:0] r_vclock;

    t_bstate r_state, n_state;
    t_cmd    r_cmd;
    logic [QW-1:0]    r_win;
    logic             r_found;
    logic [TAG_W-1:0] r_ftag;
    logic [LEN_W-1:0] r_rdata;
    logic [31:0]      r_prod;
    logic             r_upd;
    logic             r_enq_ok;
    logic [LEN_W-1:0] r_slen;

    logic             r_ovalid;
    t_status          r_ostatus;
    logic [1:0]       r_oq;
    logic [LEN_W-1:0] r_olen;
    logic [TAG_W-1:0] r_ovt;

    // combinational selection
    logic [QW-1:0] w_win;
    logic          w_found;
    logic [QW-1:0] w_q;
    logic          w_qok;

    always_comb begin
        w_win   = '0;
        w_found = 1'b0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            if (r_count[i] != '0 && (!w_found || r_finish[i] < r_finish[w_win])) begin
                w_found = 1'b1;
                w_win   = QW'(i);
            end
        end
    end

    assign w_q   = QW'(r_cmd.queue_sel);
    assign w_qok = ({1'b0, r_cmd.queue_sel} < 3'(NUM_QUEUES)) &&
                   (r_count[w_q] != CW'(FIFO_DEPTH));

    assign o_ready = (r_state == BS_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (i_valid) n_state = BS_READ;
            BS_READ: n_state = BS_TAG;
            BS_TAG:  n_state = BS_OUT;
            BS_OUT:  if (!r_ovalid || i_ready) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    logic [PW-1:0] w_nh;
    assign w_nh = (r_head[r_win] == PW'(FIFO_DEPTH - 1)) ? '0 : r_head[r_win] + 1'b1;

    always_ff @(posedge i_clk) begin
        // READ: latch selection and enq check, fetch head word (TAG: next head)
        if (r_state == BS_IDLE && i_valid) r_cmd <= i_cmd;
        if (r_state == BS_READ) begin
            r_win    <= w_win;
            r_found  <= w_found;
            r_ftag   <= r_finish[w_win];
            r_rdata  <= r_fifo[{w_win, r_head[w_win]}];
            r_enq_ok <= w_qok;
        end
        if (r_state == BS_TAG) begin
            if (r_cmd.action == ACT_SERVE) begin
                r_slen  <= r_found ? r_rdata : '0;
                r_rdata <= r_fifo[{r_win, w_nh}];
                r_upd   <= r_found && (r_count[r_win] != CW'(1));
            end else begin
                r_prod  <= 32'(r_cmd.packet_len) * 32'(r_wgt[w_q]);
                r_slen  <= '0;
                // count was bumped in READ, so one entry means the queue was empty
                r_upd   <= r_enq_ok && (r_count[w_q] == CW'(1));
            end
        end
        if (r_state == BS_READ && r_cmd.action == ACT_ENQ && w_qok)
            r_fifo[{w_q, r_tail[w_q]}] <= r_cmd.packet_len;

        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_vclock <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0; r_tail[i] <= '0; r_count[i] <= '0;
                r_finish[i] <= '0;
            end
            for (int i = 0; i < NUM_REGS; i++) r_wgt[i] <= WGT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_wgt[i_cfg_idx] <= i_cfg_data;
            if (r_state == BS_READ && r_cmd.action == ACT_ENQ && w_qok) begin
                r_tail[w_q]  <= (r_tail[w_q] == PW'(FIFO_DEPTH - 1)) ? '0 : r_tail[w_q] + 1'b1;
                r_count[w_q] <= r_count[w_q] + 1'b1;
            end
            if (r_state == BS_TAG && r_cmd.action == ACT_SERVE && r_found) begin
                r_head[r_win]  <= w_nh;
                r_count[r_win] <= r_count[r_win] - 1'b1;
                r_vclock       <= r_ftag;
            end
            if (r_state == BS_OUT && n_state == BS_IDLE) begin
                if (r_upd) begin
                    if (r_cmd.action == ACT_SERVE)
                        r_finish[r_win] <= sat_add(r_ftag,
                                                   32'(r_rdata) * 32'(r_wgt[r_win]));
                    else
                        r_finish[w_q] <= sat_add(r_vclock, r_prod);
                end
                r_ovalid <= 1'b1;
                r_oq     <= (r_cmd.action == ACT_SERVE && r_found) ? 2'(r_win) : 2'd0;
                r_olen   <= r_slen;
                r_ovt    <= r_vclock;
                if (r_cmd.action == ACT_SERVE)
                    r_ostatus <= r_found ? ST_SERVED : ST_IDLE;
                else
                    r_ostatus <= r_enq_ok ? ST_ENQUEUED : ST_DROPPED;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_served_queue = r_oq;
    assign o_served_len   = r_olen;
    assign o_virtual_time = r_ovt;

`ifndef ASSERT_OFF
    a_vclock_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_vclock >= $past(r_vclock)) || $past(r_cmd.action == ACT_SERVE))
        else $error("vclock moved on enqueue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_IDLE) |-> !o_ready) else $error("ready while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] <= CW'(FIFO_DEPTH)) else $error("queue 0 count overflow");
`endif

endmodule

@@ src/weighted_fair_queue_scheduler_unit.sv @@
// Top level: weighted fair queue scheduler, front queue plus execution back end.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: action[0], queue_sel[2:1], packet_len[18:3]
//  m_axis  | out | tdata: status[1:0], served_queue[3:2], served_len[19:4], vtime[67:20]
//  cfg     | in  | index[1:0], data[15:0]
//
// Each item passes through four steps in the back end (accept, select and fetch, tag, result).
// The front queue holds two commands so input is taken while the back end works.
// Reset is synchronous active low; all queues empty, vclock zero, weights 1.0.
// A result that is still waiting holds the back end in its result step.
`timescale 1ns / 1ps

module weighted_fair_queue_scheduler_unit import wfq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action, queue_sel, packet_len
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, served_queue, served_len, virtual_time
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd w_in_cmd, w_q_cmd;
    logic w_q_valid, w_q_ready;
    t_status          w_status;
    logic [1:0]       w_sq;
    logic [LEN_W-1:0] w_slen;
    logic [TAG_W-1:0] w_vt;

    assign w_in_cmd.action     = t_action'(s_axis_tdata[0]);
    assign w_in_cmd.queue_sel  = s_axis_tdata[2:1];
    assign w_in_cmd.packet_len = s_axis_tdata[18:3];
    assign o_cfg_ready = 1'b1;

    wfq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in_cmd),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_q_cmd)
    );

    wfq_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_q_cmd),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_served_queue(w_sq), .o_served_len(w_slen),
        .o_virtual_time(w_vt)
    );

    assign m_axis_tdata = {4'd0, w_vt, w_slen, w_sq, w_status};

endmodule
